// File: design/fsmq_pkg.sv
package fsmq_pkg;

    // Field and register widths fixed by the interface
    localparam int ACTION_W    = 2;
    localparam int BYTE_W      = 8;
    localparam int SIZE_W      = 7;
    localparam int STATUS_W    = 3;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int MAX_MSG_W   = 7;
    localparam int SLOTS_CFG_W = 5;

    // Parameter defaults
    localparam int DEF_SLOTS      = 16;
    localparam int DEF_SLOT_BYTES = 64;

    // Configuration register reset values
    localparam logic [MAX_MSG_W-1:0]   MAX_MSG_RST = 7'd64;
    localparam logic [SLOTS_CFG_W-1:0] SLOTS_RST   = 5'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_COMMIT = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_BYTE     = 3'd4,
        ST_ZERO     = 3'd5,
        ST_DISCARD  = 3'd6,
        ST_CLEARED  = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_SIZE,
        S_RD_BYTES
    } state_t;

endpackage

// File: design/fsmq_ram.sv
module fsmq_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] q
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            q <= mem[raddr];
        end
    end

endmodule

// File: design/fsmq_ctrl.sv
module fsmq_ctrl #(
    parameter int SLOTS      = fsmq_pkg::DEF_SLOTS,
    parameter int SLOT_BYTES = fsmq_pkg::DEF_SLOT_BYTES,
    parameter int PTR_W      = $clog2(SLOTS),
    parameter int OFF_W      = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1,
    parameter int CNT_W      = $clog2(SLOT_BYTES + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fsmq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fsmq_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fsmq_pkg::ACTION_W-1:0]     action,
    input  logic [fsmq_pkg::BYTE_W-1:0]       data_byte,
    input  logic [fsmq_pkg::SIZE_W-1:0]       read_limit,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fsmq_pkg::STATUS_W-1:0]     status,
    output logic [fsmq_pkg::BYTE_W-1:0]       byte_out,
    output logic [fsmq_pkg::SIZE_W-1:0]       message_size,
    output logic                              last,
    output logic                              bwe,
    output logic [PTR_W+OFF_W-1:0]            bwaddr,
    output logic [fsmq_pkg::BYTE_W-1:0]       bwdata,
    output logic                              bre,
    output logic [PTR_W+OFF_W-1:0]            braddr,
    input  logic [fsmq_pkg::BYTE_W-1:0]       bq,
    output logic                              swe,
    output logic [PTR_W-1:0]                  swaddr,
    output logic [CNT_W-1:0]                  swdata,
    output logic                              sre,
    output logic [PTR_W-1:0]                  sraddr,
    input  logic [CNT_W-1:0]                  sq
);

    localparam int LEN_W = $clog2(SLOTS + 1);
    localparam int RL_W  = (LEN_W > fsmq_pkg::SLOTS_CFG_W) ? LEN_W : fsmq_pkg::SLOTS_CFG_W;

    fsmq_pkg::state_t  state_reg, state_next;
    fsmq_pkg::status_t status_reg, status_next;

    logic [PTR_W-1:0]                   head_reg, head_next;
    logic [PTR_W-1:0]                   tail_reg, tail_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic                               ovf_reg, ovf_next;
    logic [fsmq_pkg::MAX_MSG_W-1:0]     max_reg, max_next;
    logic [fsmq_pkg::SLOTS_CFG_W-1:0]   n_reg, n_next;
    logic                               out_valid_reg, out_valid_next;
    logic [fsmq_pkg::SIZE_W-1:0]        size_reg, size_next;
    logic                               last_reg, last_next;
    logic [PTR_W-1:0]                   rd_slot_reg, rd_slot_next;
    logic [fsmq_pkg::SIZE_W-1:0]        limit_reg, limit_next;
    logic [CNT_W-1:0]                   idx_reg, idx_next;
    logic [CNT_W-1:0]                   rd_size_reg, rd_size_next;

    logic                               out_free;
    logic                               accept;
    fsmq_pkg::action_t                  act;
    logic [fsmq_pkg::MAX_MSG_W-1:0]     eff_max;
    logic [RL_W-1:0]                    n_ext;
    logic [RL_W-1:0]                    ring_len;
    logic [PTR_W-1:0]                   tail_adv;
    logic [PTR_W-1:0]                   head_adv;
    logic [CNT_W-1:0]                   rd_sz;
    logic                               rd_over;
    logic [CNT_W-1:0]                   idx_inc;
    logic [CNT_W-1:0]                   cnt_inc;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [RL_W-1:0] len);
        logic [RL_W-1:0] q;
        begin
            q = RL_W'(p) + RL_W'(1);
            return (q >= len) ? '0 : q[PTR_W-1:0];
        end
    endfunction

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == fsmq_pkg::S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;
    assign act      = fsmq_pkg::action_t'(action);

    assign eff_max  = (max_reg > fsmq_pkg::MAX_MSG_W'(SLOT_BYTES))
                      ? fsmq_pkg::MAX_MSG_W'(SLOT_BYTES) : max_reg;
    assign n_ext    = RL_W'(n_reg);
    assign ring_len = (n_ext < RL_W'(2)) ? RL_W'(2)
                      : ((n_ext > RL_W'(SLOTS)) ? RL_W'(SLOTS) : n_ext);
    assign tail_adv = adv(tail_reg, ring_len);
    assign head_adv = adv(head_reg, ring_len);

    assign rd_sz    = (sq > CNT_W'(SLOT_BYTES)) ? CNT_W'(SLOT_BYTES) : sq;
    assign rd_over  = fsmq_pkg::SIZE_W'(rd_sz) > limit_reg;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign cnt_inc  = cnt_reg + CNT_W'(1);

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign message_size = size_reg;
    assign last         = last_reg;
    assign byte_out     = (status_reg == fsmq_pkg::ST_BYTE) ? bq : '0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fsmq_pkg::S_IDLE:
            begin
                if (accept && (act == fsmq_pkg::ACT_READ) && (head_reg != tail_reg))
                begin
                    state_next = fsmq_pkg::S_RD_SIZE;
                end
            end
            fsmq_pkg::S_RD_SIZE:
            begin
                if (out_free)
                begin
                    if (rd_over || (rd_sz <= CNT_W'(1)))
                    begin
                        state_next = fsmq_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = fsmq_pkg::S_RD_BYTES;
                    end
                end
            end
            fsmq_pkg::S_RD_BYTES:
            begin
                if (out_free && (idx_inc == rd_size_reg))
                begin
                    state_next = fsmq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fsmq_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory requests and result register
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        max_next       = max_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        size_next      = size_reg;
        last_next      = last_reg;
        rd_slot_next   = rd_slot_reg;
        limit_next     = limit_reg;
        idx_next       = idx_reg;
        rd_size_next   = rd_size_reg;

        bwe    = 1'b0;
        bwaddr = {tail_reg, cnt_reg[OFF_W-1:0]};
        bwdata = data_byte;
        bre    = 1'b0;
        braddr = {rd_slot_reg, idx_reg[OFF_W-1:0]};
        swe    = 1'b0;
        swaddr = tail_reg;
        swdata = cnt_reg;
        sre    = 1'b0;
        sraddr = head_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                fsmq_pkg::CFG_MAX_MSG:      max_next = cfg_data;
                fsmq_pkg::CFG_SLOTS_IN_USE: n_next   = cfg_data[fsmq_pkg::SLOTS_CFG_W-1:0];
                default:                    max_next = max_reg;
            endcase
        end

        unique case (state_reg)
            fsmq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    unique case (act)
                        fsmq_pkg::ACT_PUSH:
                        begin
                            if (!ovf_reg && (fsmq_pkg::MAX_MSG_W'(cnt_reg) < eff_max))
                            begin
                                bwe         = 1'b1;
                                cnt_next    = cnt_inc;
                                status_next = fsmq_pkg::ST_ACCEPTED;
                                size_next   = fsmq_pkg::SIZE_W'(cnt_inc);
                            end
                            else
                            begin
                                ovf_next    = 1'b1;
                                status_next = fsmq_pkg::ST_TOO_LONG;
                                size_next   = fsmq_pkg::SIZE_W'(cnt_reg);
                            end
                        end
                        fsmq_pkg::ACT_COMMIT:
                        begin
                            size_next = fsmq_pkg::SIZE_W'(cnt_reg);
                            if (ovf_reg)
                            begin
                                status_next = fsmq_pkg::ST_TOO_LONG;
                            end
                            else if (tail_adv == head_reg)
                            begin
                                status_next = fsmq_pkg::ST_FULL;
                            end
                            else
                            begin
                                swe         = 1'b1;
                                tail_next   = tail_adv;
                                status_next = fsmq_pkg::ST_ACCEPTED;
                            end
                            cnt_next = '0;
                            ovf_next = 1'b0;
                        end
                        fsmq_pkg::ACT_READ:
                        begin
                            if (head_reg == tail_reg)
                            begin
                                status_next = fsmq_pkg::ST_EMPTY;
                                size_next   = '0;
                            end
                            else
                            begin
                                // Size lookup first; the result follows from S_RD_SIZE once the output is free
                                out_valid_next = out_valid_reg && out_stall;
                                sre            = 1'b1;
                                rd_slot_next   = head_reg;
                                head_next      = head_adv;
                                limit_next     = read_limit;
                                idx_next       = '0;
                            end
                        end
                        fsmq_pkg::ACT_CLEAR:
                        begin
                            head_next   = '0;
                            tail_next   = '0;
                            cnt_next    = '0;
                            ovf_next    = 1'b0;
                            status_next = fsmq_pkg::ST_CLEARED;
                            size_next   = '0;
                        end
                        default:
                        begin
                            status_next = fsmq_pkg::ST_CLEARED;
                        end
                    endcase
                end
            end
            fsmq_pkg::S_RD_SIZE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (rd_over)
                    begin
                        status_next = fsmq_pkg::ST_DISCARD;
                        size_next   = fsmq_pkg::SIZE_W'(rd_sz);
                    end
                    else if (rd_sz == '0)
                    begin
                        status_next = fsmq_pkg::ST_ZERO;
                        size_next   = '0;
                    end
                    else
                    begin
                        // First byte; idx is zero here
                        bre          = 1'b1;
                        status_next  = fsmq_pkg::ST_BYTE;
                        size_next    = fsmq_pkg::SIZE_W'(rd_sz);
                        last_next    = (rd_sz == CNT_W'(1));
                        rd_size_next = rd_sz;
                        idx_next     = idx_inc;
                    end
                end
            end
            fsmq_pkg::S_RD_BYTES:
            begin
                if (out_free)
                begin
                    bre            = 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = fsmq_pkg::ST_BYTE;
                    size_next      = fsmq_pkg::SIZE_W'(rd_size_reg);
                    last_next      = (idx_inc == rd_size_reg);
                    idx_next       = idx_inc;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsmq_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            max_reg       <= fsmq_pkg::MAX_MSG_RST;
            n_reg         <= fsmq_pkg::SLOTS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            max_reg       <= max_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        size_reg    <= size_next;
        last_reg    <= last_next;
        rd_slot_reg <= rd_slot_next;
        limit_reg   <= limit_next;
        idx_reg     <= idx_next;
        rd_size_reg <= rd_size_next;
    end

endmodule

// File: design/fixed_slot_message_queue.sv
// Fixed-slot message queue: a ring of up to SLOTS message slots of up to SLOT_BYTES bytes each,
// held in a byte memory and a slot-size memory, both with synchronous, registered reads.
// Push, commit and clear each give one result. A read of an empty ring gives one result;
// any other read first looks up the slot size and then gives one result per cycle while
// the output is not stalled: one per byte, or a single result when the message is
// discarded or has zero size. Input is stalled while a read streams and whenever the
// result register is full and stalled. The memories get no clearing pass after reset,
// and a read does not check that its slot was written by a commit.
module fixed_slot_message_queue #(
    parameter int SLOTS      = fsmq_pkg::DEF_SLOTS,
    parameter int SLOT_BYTES = fsmq_pkg::DEF_SLOT_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fsmq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsmq_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [fsmq_pkg::ACTION_W-1:0]  action,
    input  logic [fsmq_pkg::BYTE_W-1:0]    data_byte,
    input  logic [fsmq_pkg::SIZE_W-1:0]    read_limit,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fsmq_pkg::STATUS_W-1:0]  status,
    output logic [fsmq_pkg::BYTE_W-1:0]    byte_out,
    output logic [fsmq_pkg::SIZE_W-1:0]    message_size,
    output logic                           last
);

    localparam int PTR_W = $clog2(SLOTS);
    localparam int OFF_W = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int CNT_W = $clog2(SLOT_BYTES + 1);
    localparam int BA_W  = PTR_W + OFF_W;

    logic                        bwe;
    logic [BA_W-1:0]             bwaddr;
    logic [fsmq_pkg::BYTE_W-1:0] bwdata;
    logic                        bre;
    logic [BA_W-1:0]             braddr;
    logic [fsmq_pkg::BYTE_W-1:0] bq;
    logic                        swe;
    logic [PTR_W-1:0]            swaddr;
    logic [CNT_W-1:0]            swdata;
    logic                        sre;
    logic [PTR_W-1:0]            sraddr;
    logic [CNT_W-1:0]            sq;

    fsmq_ram #(
        .DATA_W (fsmq_pkg::BYTE_W),
        .ADDR_W (BA_W)
    ) u_byte_ram (
        .clk   (clk),
        .we    (bwe),
        .waddr (bwaddr),
        .wdata (bwdata),
        .re    (bre),
        .raddr (braddr),
        .q     (bq)
    );

    fsmq_ram #(
        .DATA_W (CNT_W),
        .ADDR_W (PTR_W)
    ) u_size_ram (
        .clk   (clk),
        .we    (swe),
        .waddr (swaddr),
        .wdata (swdata),
        .re    (sre),
        .raddr (sraddr),
        .q     (sq)
    );

    fsmq_ctrl #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES),
        .PTR_W      (PTR_W),
        .OFF_W      (OFF_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .data_byte    (data_byte),
        .read_limit   (read_limit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .byte_out     (byte_out),
        .message_size (message_size),
        .last         (last),
        .bwe          (bwe),
        .bwaddr       (bwaddr),
        .bwdata       (bwdata),
        .bre          (bre),
        .braddr       (braddr),
        .bq           (bq),
        .swe          (swe),
        .swaddr       (swaddr),
        .swdata       (swdata),
        .sre          (sre),
        .sraddr       (sraddr),
        .sq           (sq)
    );

endmodule

// File: tb/tb.sv
module tb;
    import fsmq_pkg::*;

    localparam int SLOTS          = DEF_SLOTS;
    localparam int SLOT_BYTES     = DEF_SLOT_BYTES;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 20;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 80;

    typedef struct {
        status_t           st;
        logic [BYTE_W-1:0] data;
        logic [SIZE_W-1:0] size;
        logic              fin;
    } reply_t;

    typedef struct {
        bit                   set_regs;
        logic [CFG_W-1:0]     max_v;
        logic [CFG_W-1:0]     slots_v;
        action_t              act;
        logic [BYTE_W-1:0]    data;
        logic [SIZE_W-1:0]    limit;
        bit                   typed;
        status_t              st;
        logic [SIZE_W-1:0]    sz;
    } plan_row_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [ACTION_W-1:0]  action     = ACT_PUSH;
    logic [BYTE_W-1:0]    data_byte  = '0;
    logic [SIZE_W-1:0]    read_limit = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [BYTE_W-1:0]    byte_out;
    logic [SIZE_W-1:0]    message_size;
    logic                 last;

    fixed_slot_message_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .data_byte    (data_byte),
        .read_limit   (read_limit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .byte_out     (byte_out),
        .message_size (message_size),
        .last         (last)
    );

    always #1 clk = ~clk;

    // Ring model
    logic [BYTE_W-1:0]      ring_bytes [SLOTS*SLOT_BYTES];
    logic [SIZE_W-1:0]      ring_sizes [SLOTS];
    bit                     size_written [SLOTS];
    int unsigned            head_idx;
    int unsigned            tail_idx;
    int unsigned            staged;
    bit                     staged_overflow;
    logic [MAX_MSG_W-1:0]   max_msg_cfg = MAX_MSG_RST;
    logic [SLOTS_CFG_W-1:0] ring_cfg    = SLOTS_RST;

    reply_t      replies_due[$];
    int unsigned mismatches   = 0;
    int unsigned items_sent   = 0;
    int unsigned replies_seen = 0;
    int unsigned bytes_seen   = 0;
    int unsigned settings     = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left    = 0;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;

    function automatic int unsigned ring_len();
        int unsigned n;
        n = ring_cfg;
        if (n < 2) n = 2;
        if (n > SLOTS) n = SLOTS;
        return n;
    endfunction

    function automatic int unsigned msg_cap();
        return (max_msg_cfg > SLOT_BYTES) ? SLOT_BYTES : max_msg_cfg;
    endfunction

    function automatic int unsigned next_slot(input int unsigned p);
        return (p + 1 >= ring_len()) ? 0 : p + 1;
    endfunction

    function automatic void owe_reply(input status_t st, input logic [BYTE_W-1:0] b,
                                      input int unsigned sz, input bit fin);
        reply_t r;
        r.st   = st;
        r.data = b;
        r.size = sz[SIZE_W-1:0];
        r.fin  = fin;
        replies_due.push_back(r);
    endfunction

    function automatic void ring_model_step(input action_t act, input logic [BYTE_W-1:0] d,
                                            input logic [SIZE_W-1:0] lim);
        int unsigned len;
        int unsigned slot;
        case (act)
            ACT_PUSH:
            begin
                if (!staged_overflow && staged < msg_cap())
                begin
                    ring_bytes[tail_idx*SLOT_BYTES + staged] = d;
                    staged++;
                    owe_reply(ST_ACCEPTED, '0, staged, 1'b1);
                end
                else
                begin
                    staged_overflow = 1'b1;
                    owe_reply(ST_TOO_LONG, '0, staged, 1'b1);
                end
            end
            ACT_COMMIT:
            begin
                if (staged_overflow)
                    owe_reply(ST_TOO_LONG, '0, staged, 1'b1);
                else if (next_slot(tail_idx) == head_idx)
                    owe_reply(ST_FULL, '0, staged, 1'b1);
                else
                begin
                    ring_sizes[tail_idx]   = staged[SIZE_W-1:0];
                    size_written[tail_idx] = 1'b1;
                    tail_idx = next_slot(tail_idx);
                    owe_reply(ST_ACCEPTED, '0, staged, 1'b1);
                end
                staged          = 0;
                staged_overflow = 1'b0;
            end
            ACT_READ:
            begin
                if (head_idx == tail_idx)
                    owe_reply(ST_EMPTY, '0, 0, 1'b1);
                else
                begin
                    len = ring_sizes[head_idx];
                    if (len > SLOT_BYTES) len = SLOT_BYTES;
                    slot     = head_idx;
                    head_idx = next_slot(head_idx);
                    if (len > lim)
                        owe_reply(ST_DISCARD, '0, len, 1'b1);
                    else if (len == 0)
                        owe_reply(ST_ZERO, '0, 0, 1'b1);
                    else
                        for (int unsigned i = 0; i < len; i++)
                            owe_reply(ST_BYTE, ring_bytes[slot*SLOT_BYTES + i], len,
                                      i + 1 == len);
                end
            end
            default:
            begin
                head_idx        = 0;
                tail_idx        = 0;
                staged          = 0;
                staged_overflow = 1'b0;
                owe_reply(ST_CLEARED, '0, 0, 1'b1);
            end
        endcase
    endfunction

    // Present one transaction and wait for the block to take it
    task automatic offer(input action_t a, input logic [BYTE_W-1:0] d,
                         input logic [SIZE_W-1:0] lim);
        action_t act;
        act = a;
        // never pop a slot whose contents were never committed
        if (act == ACT_READ && head_idx != tail_idx && !size_written[head_idx])
            act = ACT_COMMIT;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        data_byte  <= d;
        read_limit <= lim;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ring_model_step(act, d, lim);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (replies_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] max_v, input logic [CFG_W-1:0] slots_v);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_MSG;
        cfg_data  <= max_v;
        @(posedge clk);
        max_msg_cfg = max_v[MAX_MSG_W-1:0];
        cfg_index <= CFG_SLOTS_IN_USE;
        cfg_data  <= slots_v;
        @(posedge clk);
        ring_cfg = slots_v[SLOTS_CFG_W-1:0];
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic random_traffic(input int unsigned n_items);
        int unsigned goal;
        int unsigned pick;
        int unsigned cap;
        int unsigned k;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                cap = msg_cap();
                case ($urandom_range(0, 9))
                    0:       k = cap;
                    1:       k = cap + $urandom_range(1, 2);
                    2:       k = $urandom_range(0, SLOT_BYTES);
                    default: k = (cap < 6) ? $urandom_range(0, cap) : $urandom_range(0, 6);
                endcase
                repeat (k) offer(ACT_PUSH, BYTE_W'($urandom_range(0, 255)),
                                 SIZE_W'($urandom_range(0, 64)));
                offer(ACT_COMMIT, BYTE_W'($urandom_range(0, 255)),
                      SIZE_W'($urandom_range(0, 64)));
            end
            else if (pick < 90)
                offer(ACT_READ, BYTE_W'($urandom_range(0, 255)),
                      ($urandom_range(0, 9) < 7) ? 7'd64 : SIZE_W'($urandom_range(0, 64)));
            else if (pick < 94)
                offer(ACT_CLEAR, BYTE_W'($urandom_range(0, 255)),
                      SIZE_W'($urandom_range(0, 64)));
            else
                offer(action_t'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                      SIZE_W'($urandom_range(0, 64)));
        end
    endtask

    // Result side: check each result against the oldest owed reply
    always @(posedge clk)
    begin : result_check
        reply_t want;
        if (out_valid && !out_stall)
        begin
            replies_seen++;
            if (status == ST_BYTE) bytes_seen++;
            if (replies_due.size() == 0)
            begin
                $error("unexpected result: status %0d, byte %0d, size %0d, last %0d",
                       status, byte_out, message_size, last);
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    mismatches++;
                end
                if (byte_out !== want.data)
                begin
                    $error("byte_out: expected %0d, got %0d", want.data, byte_out);
                    mismatches++;
                end
                if (message_size !== want.size)
                begin
                    $error("message_size: expected %0d, got %0d", want.size, message_size);
                    mismatches++;
                end
                if (last !== want.fin)
                begin
                    $error("last: expected %0d, got %0d", want.fin, last);
                    mismatches++;
                end
            end
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        plan_row_t plan[$];
        plan_row_t row;
        int unsigned phase_max   [PHASES] = '{64, 5, 127, 64, 0, 20};
        int unsigned phase_slots [PHASES] = '{16, 3, 31, 1, 4, 9};

        for (int i = 0; i < SLOTS; i++) size_written[i] = 1'b0;
        head_idx        = 0;
        tail_idx        = 0;
        staged          = 0;
        staged_overflow = 1'b0;

        // set_regs, max, slots, action, data, limit, typed, status, size
        plan.push_back('{0, 0, 0, ACT_READ,   8'h00, 7'd64, 1, ST_EMPTY,    7'd0});
        plan.push_back('{0, 0, 0, ACT_COMMIT, 8'h00, 7'd0,  1, ST_ACCEPTED, 7'd0});
        plan.push_back('{0, 0, 0, ACT_READ,   8'h00, 7'd0,  1, ST_ZERO,     7'd0});
        plan.push_back('{0, 0, 0, ACT_PUSH,   8'h00, 7'd0,  1, ST_ACCEPTED, 7'd1});
        plan.push_back('{0, 0, 0, ACT_PUSH,   8'hFF, 7'd64, 1, ST_ACCEPTED, 7'd2});
        plan.push_back('{0, 0, 0, ACT_PUSH,   8'hA5, 7'd0,  1, ST_ACCEPTED, 7'd3});
        plan.push_back('{0, 0, 0, ACT_COMMIT, 8'h00, 7'd0,  1, ST_ACCEPTED, 7'd3});
        plan.push_back('{0, 0, 0, ACT_READ,   8'h00, 7'd2,  1, ST_DISCARD,  7'd3});
        plan.push_back('{0, 0, 0, ACT_PUSH,   8'h5A, 7'd0,  1, ST_ACCEPTED, 7'd1});
        plan.push_back('{0, 0, 0, ACT_PUSH,   8'h81, 7'd0,  1, ST_ACCEPTED, 7'd2});
        plan.push_back('{0, 0, 0, ACT_COMMIT, 8'hFF, 7'd0,  1, ST_ACCEPTED, 7'd2});
        plan.push_back('{0, 0, 0, ACT_READ,   8'hFF, 7'd64, 0, ST_BYTE,     7'd0});
        plan.push_back('{0, 0, 0, ACT_PUSH,   8'h3C, 7'd0,  1, ST_ACCEPTED, 7'd1});
        plan.push_back('{0, 0, 0, ACT_COMMIT, 8'h00, 7'd0,  1, ST_ACCEPTED, 7'd1});
        plan.push_back('{0, 0, 0, ACT_CLEAR,  8'hFF, 7'd64, 1, ST_CLEARED,  7'd0});
        plan.push_back('{0, 0, 0, ACT_READ,   8'h00, 7'd64, 1, ST_EMPTY,    7'd0});
        // nothing fits and the ring holds a single message
        plan.push_back('{1, 0, 0, ACT_PUSH,   8'h00, 7'd0,  0, ST_BYTE,     7'd0});
        plan.push_back('{0, 0, 0, ACT_PUSH,   8'h77, 7'd0,  1, ST_TOO_LONG, 7'd0});
        plan.push_back('{0, 0, 0, ACT_COMMIT, 8'h00, 7'd0,  1, ST_TOO_LONG, 7'd0});
        plan.push_back('{0, 0, 0, ACT_COMMIT, 8'h00, 7'd0,  1, ST_ACCEPTED, 7'd0});
        plan.push_back('{0, 0, 0, ACT_COMMIT, 8'h00, 7'd0,  1, ST_FULL,     7'd0});
        plan.push_back('{0, 0, 0, ACT_READ,   8'h00, 7'd0,  1, ST_ZERO,     7'd0});
        // registers above their useful range saturate
        plan.push_back('{1, 127, 31, ACT_PUSH, 8'h80, 7'd0, 1, ST_ACCEPTED, 7'd1});
        plan.push_back('{0, 0, 0, ACT_COMMIT, 8'h00, 7'd0,  1, ST_ACCEPTED, 7'd1});
        plan.push_back('{0, 0, 0, ACT_READ,   8'h00, 7'd64, 0, ST_BYTE,     7'd0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        snd_idle_pct = 14;
        rcv_idle_pct = 48;

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.set_regs) set_regs(row.max_v, row.slots_v);
            offer(row.act, row.data, row.limit);
            if (row.typed)
            begin
                void'(replies_due.pop_back());
                owe_reply(row.st, '0, row.sz, 1'b1);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 2)
            begin
                snd_idle_pct = 48;
                rcv_idle_pct = 14;
            end
            if (p == 4)
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            set_regs(CFG_W'(phase_max[p]), CFG_W'(phase_slots[p]));
            // hold the receiver so the block backs up onto its input
            if (p == 0) hold_left = HOLD_CYCLES;
            random_traffic(PHASE_ITEMS);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            $error("%0d results never arrived", replies_due.size());
            mismatches++;
        end
        $display("Sent %0d transactions under %0d register settings, directed then random.",
                 items_sent, settings);
        $display("Checked %0d results, %0d of them streamed message bytes; %0d mismatches.",
                 replies_seen, bytes_seen, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
